### design/pll_frequency_word_calc_core_assert.svh
// Assertion macros shared by the frequency word calculator modules.
// Expects clk and rst_n in the scope of each use.
`ifndef PLL_FREQUENCY_WORD_CALC_CORE_ASSERT_SVH
`define PLL_FREQUENCY_WORD_CALC_CORE_ASSERT_SVH

// Same-cycle implication.
`define PWC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PWC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/pwc_pkg.sv
// Types, constants and helper functions for the PLL frequency word calculator.
// No dependencies.
package pwc_pkg;

  localparam int FREQ_W  = 16;
  localparam int PFD_W   = 9;
  localparam int DIVD_W  = 19;
  localparam int WORD_W  = 32;
  localparam int FRAC_W  = 10;
  localparam int KEXP_W  = 3;
  localparam int CIDX_W  = 1;

  localparam logic [FREQ_W-1:0] FREQ_MIN = 16'd350;
  localparam logic [FREQ_W-1:0] FREQ_MAX = 16'd44000;
  localparam logic [FRAC_W-1:0] MOD_FULL = 10'd1000;
  localparam logic [WORD_W-1:0] R1_BASE  = 32'h0000_8001;
  localparam logic [WORD_W-1:0] R4_BASE  = 32'h008C_803C;

  localparam logic [PFD_W-1:0]  PFD_RESET  = 9'd250;
  localparam logic [WORD_W-1:0] MUTE_RESET = 32'h00EC_801C;

  localparam logic [CIDX_W-1:0] CFG_IDX_PFD  = 1'b0;
  localparam logic [CIDX_W-1:0] CFG_IDX_MUTE = 1'b1;

  // Clamped-frequency window (inclusive low, exclusive high) for divider 2^k
  localparam logic [FREQ_W-1:0] K_LO [6] = '{16'd22000, 16'd11000, 16'd5500,
                                              16'd2750, 16'd1380, 16'd690};
  localparam logic [FREQ_W-1:0] K_HI [6] = '{16'd44010, 16'd22010, 16'd11010,
                                              16'd5510, 16'd2760, 16'd1380};

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
  } div_ctl_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quo;
    logic [PFD_W-1:0]  rem;
  } div_sts_t;

  function automatic logic [KEXP_W-1:0] pick_k(input logic [FREQ_W-1:0] f);
    logic [KEXP_W-1:0] k;
    k = 3'd6;
    for (int i = 5; i >= 0; i--) begin
      if (f >= K_LO[i] && f < K_HI[i]) k = KEXP_W'(i);
    end
    return k;
  endfunction

  function automatic logic [FRAC_W-1:0] mod_of(input logic [1:0] fives,
                                               input logic [1:0] twos);
    logic [FRAC_W-1:0] m;
    case (fives)
      2'd0:    m = 10'd1000;
      2'd1:    m = 10'd200;
      2'd2:    m = 10'd40;
      default: m = 10'd8;
    endcase
    return m >> twos;
  endfunction

endpackage

### design/pwc_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, DIVD_W quotient bits.
// Depends on pwc_pkg and the assertion macro header.
`include "pll_frequency_word_calc_core_assert.svh"

module pwc_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  pwc_pkg::div_ctl_t        ctl,
  input  logic [pwc_pkg::PFD_W-1:0] divisor,
  output pwc_pkg::div_sts_t        sts
);
  import pwc_pkg::*;

  localparam int CNT_W = $clog2(DIVD_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DIVD_W - 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [PFD_W-1:0]  rem_r, rem_nxt;
  logic [DIVD_W-1:0] shf_r, shf_nxt;
  logic [PFD_W:0]    trial;
  logic              qbit;

  assign trial = {rem_r, shf_r[DIVD_W-1]};
  assign qbit  = (trial >= {1'b0, divisor});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    shf_nxt  = shf_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      shf_nxt  = ctl.dividend;
    end else if (busy_r) begin
      rem_nxt = qbit ? PFD_W'(trial - {1'b0, divisor}) : trial[PFD_W-1:0];
      shf_nxt = {shf_r[DIVD_W-2:0], qbit};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      rem_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      rem_r  <= rem_nxt;
    end
    shf_r <= shf_nxt;
  end

  assign sts.done = done_r;
  assign sts.quo  = shf_r;
  assign sts.rem  = rem_r;

  `PWC_ASSERT_IMPL(a_done_idle, done_r, !busy_r, "divider done while busy")
  `PWC_ASSERT_IMPL(a_cnt_range, busy_r, cnt_r <= LAST, "divider step count overrun")
  `PWC_ASSERT_IMPL(a_rem_bound, busy_r && !ctl.start, rem_r < divisor,
                   "partial remainder not below divisor")

endmodule

### design/pll_frequency_word_calc_core.sv
// Flow: after the input transfer, two passes (load plus 19 steps) through the shared
// serial divider, then the reduction states ST_RED5 and ST_RED2. Four words then leave
// one per cycle while out_stall is low; the next request can be taken the cycle after
// the last word transfer.
// Reset (rst_n, synchronous): idle, pfd_tenths = 250, mute_word = 0xEC801C.
`include "pll_frequency_word_calc_core_assert.svh"

module pll_frequency_word_calc_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [pwc_pkg::FREQ_W-1:0] in_freq_tenths,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [pwc_pkg::WORD_W-1:0] out_reg_word,
  output logic                       out_last_word,
  input  logic                       cfg_we,
  input  logic [pwc_pkg::CIDX_W-1:0] cfg_index,
  input  logic [pwc_pkg::WORD_W-1:0] cfg_wdata
);
  import pwc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV1, ST_DIV2, ST_RED5, ST_RED2, ST_OUT
  } state_t;

  localparam logic [1:0] W_MUTE = 2'd0;
  localparam logic [1:0] W_R0   = 2'd1;
  localparam logic [1:0] W_R1   = 2'd2;
  localparam logic [1:0] W_R4   = 2'd3;

  state_t            state_r, state_nxt;
  logic [PFD_W-1:0]  pfd_r, pfd_nxt;
  logic [WORD_W-1:0] mute_r, mute_nxt;
  logic [FREQ_W-1:0] int_r, int_nxt;
  logic [FRAC_W-1:0] frac_r, frac_nxt;
  logic [KEXP_W-1:0] k_r, k_nxt;
  logic [1:0]        fives_r, fives_nxt;
  logic [1:0]        twos_r, twos_nxt;
  logic [1:0]        widx_r, widx_nxt;

  logic [FREQ_W-1:0] f_clamp;
  logic [KEXP_W-1:0] k_in;
  logic [FREQ_W-1:0] fd;
  logic [PFD_W-1:0]  pfd_eff;
  logic [17:0]       prod5;
  logic [7:0]        q5;
  logic [FRAC_W-1:0] q5x5;
  logic              in_xfer, out_xfer;
  div_ctl_t          div_ctl;
  div_sts_t          div_sts;

  assign f_clamp = (in_freq_tenths < FREQ_MIN) ? FREQ_MIN :
                   (in_freq_tenths > FREQ_MAX) ? FREQ_MAX : in_freq_tenths;
  assign k_in    = pick_k(f_clamp);
  assign fd      = f_clamp << k_in;
  assign pfd_eff = (pfd_r == '0) ? PFD_W'(1) : pfd_r;

  // exact divide by 5 for multiples of 5 below 1024
  assign prod5 = frac_r * 8'd205;
  assign q5    = prod5[17:10];
  assign q5x5  = {q5, 2'b00} + {2'b00, q5};

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = (state_r == ST_OUT);
  assign out_xfer  = out_valid && !out_stall;

  always_comb begin
    div_ctl.start    = 1'b0;
    div_ctl.dividend = DIVD_W'(fd);
    if (in_xfer) begin
      div_ctl.start = 1'b1;
    end else if (state_r == ST_DIV1 && div_sts.done) begin
      div_ctl.start    = 1'b1;
      div_ctl.dividend = DIVD_W'(div_sts.rem) * DIVD_W'(1000);
    end
  end

  pwc_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (div_ctl),
    .divisor (pfd_eff),
    .sts     (div_sts)
  );

  always_comb begin
    state_nxt = state_r;
    pfd_nxt   = pfd_r;
    mute_nxt  = mute_r;
    int_nxt   = int_r;
    frac_nxt  = frac_r;
    k_nxt     = k_r;
    fives_nxt = fives_r;
    twos_nxt  = twos_r;
    widx_nxt  = widx_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_PFD:  pfd_nxt  = cfg_wdata[PFD_W-1:0];
        CFG_IDX_MUTE: mute_nxt = cfg_wdata;
        default:      ;
      endcase
    end
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          k_nxt     = k_in;
          state_nxt = ST_DIV1;
        end
      end
      ST_DIV1: begin
        if (div_sts.done) begin
          int_nxt   = div_sts.quo[FREQ_W-1:0];
          state_nxt = ST_DIV2;
        end
      end
      ST_DIV2: begin
        if (div_sts.done) begin
          frac_nxt  = div_sts.quo[FRAC_W-1:0];
          fives_nxt = 2'd0;
          twos_nxt  = 2'd0;
          state_nxt = ST_RED5;
        end
      end
      ST_RED5: begin
        if (fives_r != 2'd3 && q5x5 == frac_r) begin
          frac_nxt  = FRAC_W'(q5);
          fives_nxt = fives_r + 2'd1;
        end else begin
          state_nxt = ST_RED2;
        end
      end
      ST_RED2: begin
        if (twos_r != 2'd3 && !frac_r[0]) begin
          frac_nxt = frac_r >> 1;
          twos_nxt = twos_r + 2'd1;
        end else begin
          widx_nxt  = W_MUTE;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_xfer) begin
          widx_nxt = widx_r + 2'd1;
          if (widx_r == W_R4) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pfd_r   <= PFD_RESET;
      mute_r  <= MUTE_RESET;
      widx_r  <= W_MUTE;
    end else begin
      state_r <= state_nxt;
      pfd_r   <= pfd_nxt;
      mute_r  <= mute_nxt;
      widx_r  <= widx_nxt;
    end
    int_r   <= int_nxt;
    frac_r  <= frac_nxt;
    k_r     <= k_nxt;
    fives_r <= fives_nxt;
    twos_r  <= twos_nxt;
  end

  always_comb begin
    case (widx_r)
      W_MUTE:  out_reg_word = mute_r;
      W_R0:    out_reg_word = {1'b0, int_r, 15'd0} | (WORD_W'(frac_r) << 3);
      W_R1:    out_reg_word = R1_BASE + (WORD_W'(mod_of(fives_r, twos_r)) << 3);
      W_R4:    out_reg_word = R4_BASE + (WORD_W'(k_r) << 20);
      default: out_reg_word = mute_r;
    endcase
  end

  assign out_last_word = (widx_r == W_R4);

  `PWC_ASSERT_IMPL(a_done_state, div_sts.done,
                   state_r == ST_DIV1 || state_r == ST_DIV2,
                   "divider finished outside a divide phase")
  `PWC_ASSERT_IMPL(a_frac_range, out_valid, frac_r < MOD_FULL,
                   "fraction out of range at output")
  `PWC_ASSERT_NEXT(a_ready_after, out_xfer && out_last_word, !in_stall,
                   "not ready after final word transfer")

endmodule

### tb/tb_pll_frequency_word_calc_core.sv
// Testbench for pll_frequency_word_calc_core: checks the four register words per retune request
// against a predictor, over directed band edges, config extremes and random traffic with stalls.
// Depends on pwc_pkg and the core RTL only.
module tb_pll_frequency_word_calc_core;
  import pwc_pkg::*;

  localparam int VCO_LO_MHZ  = 2200;
  localparam int VCO_HI_MHZ  = 4400;
  localparam int MAX_KEXP    = 6;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 60;

  typedef struct {
    logic [WORD_W-1:0] word;
    logic              last;
  } reg_word_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [FREQ_W-1:0]   in_freq_tenths;
  logic                out_valid;
  logic                out_stall;
  logic [WORD_W-1:0]   out_reg_word;
  logic                out_last_word;
  logic                cfg_we;
  logic [CIDX_W-1:0]   cfg_index;
  logic [WORD_W-1:0]   cfg_wdata;

  reg_word_t           pending_words[$];
  logic [PFD_W-1:0]    pfd_shadow;
  logic [WORD_W-1:0]   mute_shadow;
  bit                  idle_on;
  int                  errors;
  int                  requests_sent;
  int                  words_checked;
  int                  cycles;

  pll_frequency_word_calc_core uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_freq_tenths(in_freq_tenths),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_reg_word  (out_reg_word),
    .out_last_word (out_last_word),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d words outstanding", $time, pending_words.size());
      $display("tb_pll_frequency_word_calc_core: FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= idle_on && ($urandom_range(99) < 33);
  end

  // Word checker: one transfer per accepted result word
  always @(posedge clk) begin
    reg_word_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: expected none, actual %h last %b",
                 $time, out_reg_word, out_last_word);
      end else begin
        exp_w = pending_words.pop_front();
        words_checked++;
        if (out_reg_word !== exp_w.word) begin
          errors++;
          $display("%0t: reg_word mismatch: expected %h, actual %h",
                   $time, exp_w.word, out_reg_word);
        end
        if (out_last_word !== exp_w.last) begin
          errors++;
          $display("%0t: last_word mismatch: expected %b, actual %b",
                   $time, exp_w.last, out_last_word);
        end
      end
    end
  end

  task automatic predict_words(input logic [FREQ_W-1:0] req);
    logic [63:0] f;
    logic [63:0] pfd;
    logic [63:0] fd;
    logic [63:0] whole;
    logic [63:0] frac;
    logic [63:0] modv;
    logic [63:0] vco;
    logic [63:0] r0;
    int          kexp;
    bit          found;
    f = req;
    if (f < FREQ_MIN) f = FREQ_MIN;
    if (f > FREQ_MAX) f = FREQ_MAX;
    pfd = (pfd_shadow == '0) ? 64'd1 : 64'(pfd_shadow);
    kexp = MAX_KEXP;
    found = 0;
    for (int i = 0; i < MAX_KEXP; i++) begin
      vco = (f / 10) << i;
      if (!found && vco >= VCO_LO_MHZ && vco <= VCO_HI_MHZ) begin
        kexp = i;
        found = 1;
      end
    end
    fd = f << kexp;
    whole = fd / pfd;
    frac = ((fd * MOD_FULL) / pfd) % MOD_FULL;
    modv = MOD_FULL;
    while (frac % 5 == 0 && modv % 5 == 0) begin
      frac = frac / 5;
      modv = modv / 5;
    end
    while (frac % 2 == 0 && modv % 2 == 0) begin
      frac = frac / 2;
      modv = modv / 2;
    end
    r0 = (whole << 15) + (frac << 3);
    pending_words.push_back('{mute_shadow, 1'b0});
    pending_words.push_back('{r0[WORD_W-1:0], 1'b0});
    pending_words.push_back('{WORD_W'(R1_BASE + (modv << 3)), 1'b0});
    pending_words.push_back('{WORD_W'(R4_BASE + (64'(kexp) << 20)), 1'b1});
  endtask

  task automatic send_request(input logic [FREQ_W-1:0] f);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_freq_tenths <= f;
    do @(posedge clk); while (in_stall);
    predict_words(f);
    requests_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CIDX_W-1:0] idx, input logic [WORD_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == CFG_IDX_PFD) pfd_shadow = data[PFD_W-1:0];
    else mute_shadow = data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [FREQ_W-1:0] random_freq();
    int sel;
    sel = $urandom_range(99);
    if (sel < 70) return FREQ_W'($urandom_range(FREQ_MAX, FREQ_MIN));
    if (sel < 80) return FREQ_W'($urandom_range(FREQ_MIN - 1, 0));
    if (sel < 90) return FREQ_W'($urandom_range(65535, FREQ_MAX + 1));
    return FREQ_W'($urandom());
  endfunction

  task automatic test_reset_defaults();
    send_request(16'd0);
    send_request(16'd349);
    send_request(16'd350);
    send_request(16'd44000);
    send_request(16'd44001);
    send_request(16'hFFFF);
    send_request(16'd25000);
    wait_idle();
  endtask

  task automatic test_divider_bands();
    logic [FREQ_W-1:0] edges[12];
    edges = '{16'd21999, 16'd22000, 16'd10999, 16'd11000, 16'd5499, 16'd5500,
              16'd2749, 16'd2750, 16'd1379, 16'd1380, 16'd689, 16'd690};
    foreach (edges[i]) send_request(edges[i]);
    wait_idle();
  endtask

  task automatic test_config_extremes();
    cfg_write(CFG_IDX_PFD, 32'd1);
    cfg_write(CFG_IDX_MUTE, 32'h0000_0000);
    send_request(16'd44000);
    wait_idle();
    cfg_write(CFG_IDX_PFD, 32'd0);
    cfg_write(CFG_IDX_MUTE, 32'hFFFF_FFFF);
    send_request(16'd350);
    wait_idle();
    cfg_write(CFG_IDX_PFD, 32'hFFFF_FFFF);
    send_request(16'd33333);
    wait_idle();
    cfg_write(CFG_IDX_PFD, 32'd450);
    cfg_write(CFG_IDX_MUTE, 32'hA5A5_5A5A);
    send_request(16'd22500);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    logic [WORD_W-1:0] pfd_word;
    for (int phase = 0; phase < 8; phase++) begin
      idle_on = (phase >= 2);
      pfd_word = $urandom();
      case (phase)
        2:       pfd_word[PFD_W-1:0] = 9'd1;
        5:       pfd_word[PFD_W-1:0] = 9'd511;
        6:       pfd_word[PFD_W-1:0] = 9'd0;
        7:       pfd_word[PFD_W-1:0] = 9'd450;
        default: pfd_word[PFD_W-1:0] = PFD_W'($urandom_range(450, 1));
      endcase
      cfg_write(CFG_IDX_PFD, pfd_word);
      cfg_write(CFG_IDX_MUTE, $urandom());
      repeat (55) send_request(random_freq());
      wait_idle();
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_freq_tenths = '0;
    out_stall      = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    idle_on        = 1;
    errors         = 0;
    requests_sent  = 0;
    words_checked  = 0;
    cycles         = 0;
    pfd_shadow     = PFD_RESET;
    mute_shadow    = MUTE_RESET;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_divider_bands();
    test_config_extremes();
    test_random_traffic();

    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Covered %0d retune requests and %0d register words over 8 random config phases",
             requests_sent, words_checked);
    $display("plus clamp, divider band edge and pfd/mute extreme cases; %0d errors", errors);
    if (errors == 0) begin
      $display("tb_pll_frequency_word_calc_core: PASS");
    end else begin
      $display("tb_pll_frequency_word_calc_core: FAIL");
    end
    $finish;
  end

endmodule
